>>> rtl/knx2f_pkg.sv
// Shared types and constants for the KNX two-byte float codec.
// No dependencies; the datapath, controller, top level and bench import this package.
`default_nettype none
package knx2f_pkg;

  localparam int unsigned MANT_BITS = 11;
  localparam int unsigned EXP_BITS  = 4;
  localparam int unsigned MAG_BITS  = 27;
  localparam int unsigned CNT_BITS  = EXP_BITS + 1;

  localparam logic [MANT_BITS-1:0] MANT_MASK    = 11'h7FF;
  localparam logic [15:0]          INVALID_WORD = 16'h7FFF;
  localparam logic [31:0]          POS_LIMIT    = 32'd67076096;
  localparam logic [31:0]          NEG_LIMIT    = 32'd67108864;
  localparam logic [7:0]           EXP_MAX      = 8'd15;

  localparam logic ACT_ENCODE = 1'b0;
  localparam logic ACT_DECODE = 1'b1;
  localparam logic MODE_AUTO  = 1'b0;
  localparam logic MODE_FIXED = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic fin;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/knx2f_if.sv
// Valid/ready channel interfaces for the codec's input and result beats.
// Depends on nothing but the field widths fixed by the KNX word format.
`default_nettype none
interface knx2f_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [31:0] value_times_100;
  logic               scale_mode;
  logic        [7:0]  scale_exp;
  logic        [15:0] raw_in;

  modport source (output valid, action, value_times_100, scale_mode, scale_exp, raw_in,
                  input ready);
  modport sink   (input valid, action, value_times_100, scale_mode, scale_exp, raw_in,
                  output ready);
endinterface

interface knx2f_out_if;
  logic               valid;
  logic               ready;
  logic        [15:0] raw_out;
  logic               invalid;
  logic signed [26:0] decoded_times_100;

  modport source (output valid, raw_out, invalid, decoded_times_100, input ready);
  modport sink   (input valid, raw_out, invalid, decoded_times_100, output ready);
endinterface
`default_nettype wire

>>> rtl/knx2f_dp.sv
// Datapath: operand registers, shared one-bit shifter with exponent counter,
// and the result register. Depends on knx2f_pkg.
`default_nettype none
module knx2f_dp import knx2f_pkg::*; (
  input  wire logic               clk,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  input  wire logic               in_action,
  input  wire logic signed [31:0] in_value_times_100,
  input  wire logic               in_scale_mode,
  input  wire logic        [7:0]  in_scale_exp,
  input  wire logic        [15:0] in_raw_in,
  output logic             [15:0] out_raw_out,
  output logic                    out_invalid,
  output logic signed [26:0]      out_decoded_times_100
);

  logic                 act_r, neg_r, mode_r, range_bad_r;
  logic [7:0]           expv_r;
  logic [EXP_BITS-1:0]  rexp_r;
  logic [MAG_BITS-1:0]  mag_r;
  logic [CNT_BITS-1:0]  exp_r;

  logic                 ld_neg;
  logic [31:0]          ld_mag;
  logic [MANT_BITS-1:0] dec_m;
  logic [MANT_BITS:0]   dec_m_eff;
  logic                 enc_bad;
  logic [MANT_BITS-1:0] enc_m;
  logic [15:0]          raw_nxt;
  logic                 inv_nxt;
  logic [MAG_BITS-1:0]  dec_nxt;

  always_comb begin
    ld_neg = in_value_times_100[31];
    ld_mag = ld_neg ? (32'd0 - in_value_times_100) : in_value_times_100;
    // decode mantissa: negated for negative words, zero stands for 2048
    dec_m  = in_raw_in[15] ? (~in_raw_in[MANT_BITS-1:0] + 11'd1) : in_raw_in[MANT_BITS-1:0];
    dec_m_eff = (in_raw_in[15] && dec_m == '0) ? {1'b1, {MANT_BITS{1'b0}}} : {1'b0, dec_m};
  end

  always_comb begin
    if (act_r == ACT_DECODE) begin
      sts.fin = (exp_r == {1'b0, rexp_r});
    end else if (range_bad_r) begin
      sts.fin = 1'b1;
    end else if (mode_r == MODE_AUTO) begin
      sts.fin = (mag_r[MAG_BITS-1:MANT_BITS] == '0);
    end else begin
      sts.fin = (expv_r > EXP_MAX) || (exp_r == {1'b0, expv_r[EXP_BITS-1:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r       <= in_action;
      mode_r      <= in_scale_mode;
      expv_r      <= in_scale_exp;
      rexp_r      <= in_raw_in[14:11];
      exp_r       <= '0;
      if (in_action == ACT_DECODE) begin
        neg_r       <= in_raw_in[15];
        range_bad_r <= 1'b0;
        mag_r       <= MAG_BITS'(dec_m_eff);
      end else begin
        neg_r       <= ld_neg;
        range_bad_r <= ld_neg ? (ld_mag > NEG_LIMIT) : (ld_mag > POS_LIMIT);
        mag_r       <= ld_mag[MAG_BITS-1:0];
      end
    end else if (cmd.step) begin
      exp_r <= exp_r + CNT_BITS'(1);
      if (act_r == ACT_DECODE) begin
        mag_r <= {mag_r[MAG_BITS-2:0], 1'b0};
      end else if (mode_r == MODE_AUTO) begin
        // halve, rounding up
        mag_r <= (mag_r >> 1) + MAG_BITS'(mag_r[0]);
      end else begin
        mag_r <= mag_r >> 1;
      end
    end
  end

  always_comb begin
    enc_bad = range_bad_r ||
              ((mode_r == MODE_AUTO) ? exp_r[CNT_BITS-1] : (expv_r > EXP_MAX));
    enc_m   = neg_r ? (~mag_r[MANT_BITS-1:0] + 11'd1) : mag_r[MANT_BITS-1:0];
    dec_nxt = neg_r ? (MAG_BITS'(0) - mag_r) : mag_r;
    if (act_r == ACT_DECODE) begin
      raw_nxt = '0;
      inv_nxt = 1'b0;
    end else if (enc_bad) begin
      raw_nxt = INVALID_WORD;
      inv_nxt = 1'b1;
      dec_nxt = '0;
    end else begin
      raw_nxt = {neg_r, exp_r[EXP_BITS-1:0], enc_m & MANT_MASK};
      inv_nxt = 1'b0;
      dec_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_raw_out           <= raw_nxt;
      out_invalid           <= inv_nxt;
      out_decoded_times_100 <= dec_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/knx2f_ctrl.sv
// Controller: sequences load, shift steps and result capture, and owns
// the channel handshakes. Depends on knx2f_pkg.
`default_nettype none
module knx2f_ctrl import knx2f_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output cmd_t      cmd,
  input  wire sts_t sts
);

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // no beat is taken while reset is held
  assign in_ready  = rst_n && (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load  = 1'b1;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (!sts.fin) begin
          cmd.step = 1'b1;
        end else if (out_free) begin
          // result register is free: capture and present the beat
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_runs: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_RUN))
    else $error("load did not start a run");
  a_step_xor_finish: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.step && cmd.finish))
    else $error("step and finish in one cycle");
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");
  a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("captured result not presented");
`endif

endmodule
`default_nettype wire

>>> rtl/knx_two_byte_float_codec.sv
// KNX two-byte float codec, signed hundredths <-> 16-bit KNX float word.
// Usage:
//   in_ch  (sink)   : one beat per conversion. action selects encode of
//                     value_times_100 (scale_mode/scale_exp choose automatic
//                     or fixed exponent) or decode of raw_in.
//   out_ch (source) : one beat per input beat with raw_out, invalid and
//                     decoded_times_100; unused fields read as zero.
// Sequence: an accepted input is loaded, the one-bit shifter takes n steps,
//   n being the final exponent for encode (0..16 automatic, 0..15 fixed,
//   0 when out of range) or the word's exponent for decode, and the result
//   is then captured in the output register, which raises out_ch.valid.
// Flow: one item at a time; the next input beat is taken the cycle after
//   the result is captured.
// Stall: a captured result sits in the output register until taken; the
//   next item is accepted meanwhile and holds at its last step until the
//   output register frees up.
// Reset (rst_n low, synchronous): controller returns to idle, out_ch.valid
//   drops, in_ch.ready is low while rst_n is low and rises on its release.
// Depends on knx2f_pkg, knx2f_if, knx2f_ctrl, knx2f_dp.
`default_nettype none
module knx_two_byte_float_codec import knx2f_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  knx2f_in_if.sink   in_ch,
  knx2f_out_if.source out_ch
);

  cmd_t cmd;
  sts_t sts;

  knx2f_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  knx2f_dp u_dp (
    .clk                   (clk),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_action             (in_ch.action),
    .in_value_times_100    (in_ch.value_times_100),
    .in_scale_mode         (in_ch.scale_mode),
    .in_scale_exp          (in_ch.scale_exp),
    .in_raw_in             (in_ch.raw_in),
    .out_raw_out           (out_ch.raw_out),
    .out_invalid           (out_ch.invalid),
    .out_decoded_times_100 (out_ch.decoded_times_100)
  );

endmodule
`default_nettype wire

>>> dv/tb.sv
// Self-checking bench for knx_two_byte_float_codec: a directed table, then random encode/decode
// beats under several idle/stall mixes, checked against an in-bench KNX float predictor.
// Depends on rtl/knx2f_pkg.sv, rtl/knx2f_if.sv and the codec top level.
module tb import knx2f_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    logic        act;
    logic [31:0] hundredths;
    logic        mode;
    logic [7:0]  exp_sel;
    logic [15:0] word;
  } stim_t;

  typedef struct packed {
    logic [15:0] raw;
    logic        inv;
    logic [26:0] dec;
  } result_t;

  typedef struct packed {
    stim_t   s;
    bit      typed;
    result_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;

  knx2f_in_if  in_ch ();
  knx2f_out_if out_ch ();

  knx_two_byte_float_codec DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  result_t pending_q[$];
  row_t    rows[$];
  result_t head;
  int      err_cnt = 0;
  int      src_idle_pct = 0;
  int      sink_stall_pct = 0;
  bit      hold_req = 1'b0;

  // KNX float conversion in hundredths, one result per beat
  function automatic result_t knx_convert(input stim_t s);
    result_t     r;
    logic        neg;
    logic [31:0] mag;
    logic [31:0] v;
    int unsigned e;
    r = '0;
    if (s.act == ACT_ENCODE) begin
      neg = s.hundredths[31];
      mag = neg ? (32'd0 - s.hundredths) : s.hundredths;
      r.raw = INVALID_WORD;
      r.inv = 1'b1;
      if (neg ? (mag > NEG_LIMIT) : (mag > POS_LIMIT)) return r;
      if (s.mode == MODE_AUTO) begin
        e = 0;
        // halve with round-up until the magnitude fits the mantissa
        while (mag > 32'd2047) begin
          mag = (mag >> 1) + {31'd0, mag[0]};
          e++;
        end
      end else begin
        e = 32'(s.exp_sel);
        mag = (e >= 32) ? 32'd0 : (mag >> e);
      end
      if (e > EXP_MAX) return r;
      if (neg) mag = 32'd0 - mag;
      r.raw = {neg, e[3:0], mag[10:0]};
      r.inv = 1'b0;
    end else begin
      neg = s.word[15];
      e = 32'(s.word[14:11]);
      v = {21'd0, s.word[10:0]};
      if (neg) begin
        v = (32'd0 - v) & 32'h7FF;
        // zero negative mantissa stands for -2048
        if (v == 32'd0) v = 32'd2048;
      end
      v = v << e;
      if (neg) v = 32'd0 - v;
      r.dec = v[26:0];
    end
    return r;
  endfunction

  task automatic add_row(input logic act, input logic [31:0] v, input logic mode,
                         input logic [7:0] ex, input logic [15:0] w, input bit typed,
                         input logic [15:0] raw, input logic inv, input logic [26:0] dec);
    row_t r;
    r.s     = '{act: act, hundredths: v, mode: mode, exp_sel: ex, word: w};
    r.typed = typed;
    r.want  = '{raw: raw, inv: inv, dec: dec};
    rows.push_back(r);
  endtask

  function automatic stim_t rand_item();
    stim_t       s;
    int unsigned pick;
    int          d;
    s.act  = 1'($urandom_range(0, 1));
    s.mode = 1'($urandom_range(0, 1));
    s.word = 16'($urandom);
    s.exp_sel = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 15))
                                             : 8'($urandom_range(16, 255));
    pick = $urandom_range(0, 9);
    d    = int'($urandom_range(0, 6)) - 3;
    case (pick)
      0, 1, 2, 3: s.hundredths = int'($urandom_range(0, 134184960)) - 67108864;
      4, 5:       s.hundredths = int'($urandom_range(0, 10000)) - 5000;
      6:          s.hundredths = $urandom;
      7: begin
        s.hundredths = $urandom_range(0, 1) ? (POS_LIMIT + d) : (32'd0 - NEG_LIMIT + d);
      end
      8: begin
        s.hundredths = (32'd1 << $urandom_range(0, 26)) + d;
        if ($urandom_range(0, 1)) s.hundredths = 32'd0 - s.hundredths;
      end
      default: s.hundredths = d;
    endcase
    return s;
  endfunction

  // hold valid until the beat is taken; a gap lowers valid only when one is drawn
  task automatic send_item(input stim_t s, input result_t want);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
    end
    in_ch.valid           <= 1'b1;
    in_ch.action          <= s.act;
    in_ch.value_times_100 <= s.hundredths;
    in_ch.scale_mode      <= s.mode;
    in_ch.scale_exp       <= s.exp_sel;
    in_ch.raw_in          <= s.word;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_q.push_back(want);
  endtask

  task automatic run_random(input int n_items, input int idle_pct, input int stall_pct,
                            input int hold_every);
    stim_t s;
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    for (int i = 0; i < n_items; i++) begin
      if (hold_every != 0 && i % hold_every == 0) hold_req = 1'b1;
      s = rand_item();
      send_item(s, knx_convert(s));
    end
  endtask

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_q.size() == 0) begin
        $error("result beat with nothing pending: raw_out %h", out_ch.raw_out);
        err_cnt++;
      end else begin
        head = pending_q.pop_front();
        if (out_ch.raw_out !== head.raw) begin
          $error("raw_out: expected %h, got %h", head.raw, out_ch.raw_out);
          err_cnt++;
        end
        if (out_ch.invalid !== head.inv) begin
          $error("invalid: expected %b, got %b", head.inv, out_ch.invalid);
          err_cnt++;
        end
        if (out_ch.decoded_times_100 !== head.dec) begin
          $error("decoded_times_100: expected %0d, got %0d",
                 $signed(head.dec), $signed(out_ch.decoded_times_100));
          err_cnt++;
        end
      end
    end
  end

  initial begin
    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.action          <= ACT_ENCODE;
    in_ch.value_times_100 <= '0;
    in_ch.scale_mode      <= MODE_AUTO;
    in_ch.scale_exp       <= '0;
    in_ch.raw_in          <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // act, value, mode, exponent, word, typed, raw_out, invalid, decoded
    add_row(ACT_ENCODE, 32'd0, MODE_AUTO, 8'd0, 16'h0000, 1'b1, 16'h0000, 1'b0, '0);
    add_row(ACT_ENCODE, POS_LIMIT, MODE_AUTO, 8'd0, 16'h0000, 1'b1, 16'h7FFF, 1'b0, '0);
    add_row(ACT_ENCODE, POS_LIMIT + 1, MODE_AUTO, 8'd0, 16'h0000, 1'b1, INVALID_WORD, 1'b1, '0);
    add_row(ACT_ENCODE, -NEG_LIMIT, MODE_AUTO, 8'd0, 16'h0000, 1'b1, INVALID_WORD, 1'b1, '0);
    add_row(ACT_ENCODE, -NEG_LIMIT - 1, MODE_AUTO, 8'd0, 16'h0000, 1'b1, INVALID_WORD, 1'b1, '0);
    add_row(ACT_ENCODE, 32'h7FFF_FFFF, MODE_AUTO, 8'd0, 16'hFFFF, 1'b1, INVALID_WORD, 1'b1, '0);
    add_row(ACT_ENCODE, 32'h8000_0000, MODE_FIXED, 8'd3, 16'hFFFF, 1'b1, INVALID_WORD, 1'b1, '0);
    add_row(ACT_ENCODE, -NEG_LIMIT, MODE_FIXED, 8'd15, 16'h0000, 1'b0, '0, 1'b0, '0);
    add_row(ACT_ENCODE, 32'd100, MODE_FIXED, 8'd16, 16'h0000, 1'b1, INVALID_WORD, 1'b1, '0);
    add_row(ACT_ENCODE, -32'sd1, MODE_FIXED, 8'd255, 16'h0000, 1'b1, INVALID_WORD, 1'b1, '0);
    add_row(ACT_ENCODE, -NEG_LIMIT, MODE_FIXED, 8'd32, 16'h0000, 1'b1, INVALID_WORD, 1'b1, '0);
    add_row(ACT_ENCODE, 32'd2047, MODE_FIXED, 8'd0, 16'h0000, 1'b1, 16'h07FF, 1'b0, '0);
    add_row(ACT_ENCODE, 32'd5000, MODE_FIXED, 8'd0, 16'h0000, 1'b0, '0, 1'b0, '0);
    add_row(ACT_ENCODE, -32'sd1, MODE_FIXED, 8'd4, 16'h0000, 1'b0, '0, 1'b0, '0);
    add_row(ACT_ENCODE, -32'sd1, MODE_AUTO, 8'd0, 16'h0000, 1'b1, 16'h87FF, 1'b0, '0);
    add_row(ACT_ENCODE, 32'd2048, MODE_AUTO, 8'd0, 16'h0000, 1'b0, '0, 1'b0, '0);
    add_row(ACT_ENCODE, 32'd4095, MODE_AUTO, 8'd9, 16'hFFFF, 1'b0, '0, 1'b0, '0);
    add_row(ACT_ENCODE, -32'sd4097, MODE_AUTO, 8'd0, 16'h0000, 1'b0, '0, 1'b0, '0);
    add_row(ACT_DECODE, 32'd0, MODE_AUTO, 8'd0, 16'h0000, 1'b1, 16'h0000, 1'b0, '0);
    add_row(ACT_DECODE, 32'd0, MODE_AUTO, 8'd0, 16'h7FFF, 1'b1, 16'h0000, 1'b0, 27'sd67076096);
    add_row(ACT_DECODE, 32'd0, MODE_AUTO, 8'd0, 16'h8000, 1'b1, 16'h0000, 1'b0, -27'sd2048);
    // -2^26, the most negative decoded value
    add_row(ACT_DECODE, 32'd0, MODE_AUTO, 8'd0, 16'hF800, 1'b1, 16'h0000, 1'b0, 27'h400_0000);
    add_row(ACT_DECODE, 32'd0, MODE_AUTO, 8'd0, 16'h87FF, 1'b1, 16'h0000, 1'b0, -27'sd1);
    add_row(ACT_DECODE, 32'd0, MODE_AUTO, 8'd0, 16'hFFFF, 1'b0, '0, 1'b0, '0);
    add_row(ACT_DECODE, 32'h5A5A_A5A5, MODE_FIXED, 8'hFF, 16'h1234, 1'b0, '0, 1'b0, '0);

    foreach (rows[i]) send_item(rows[i].s, rows[i].typed ? rows[i].want : knx_convert(rows[i].s));

    run_random(200, 0, 0, 0);
    run_random(200, 58, 0, 0);
    run_random(200, 0, 58, 0);
    run_random(200, 7, 7, 0);
    // long receiver hold-offs while the sender keeps offering: input must back up
    run_random(100, 0, 0, 25);
    in_ch.valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_cnt == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("tb: FAIL");
    $finish;
  end
endmodule
